@@ design/bpc_pkg.sv @@
`default_nettype none

package bpc_pkg;

   localparam int OVERSAMPLING = 2;
   localparam int UP_W         = 24 - (8 - OVERSAMPLING);
   localparam int DIV_W        = 32;
   localparam int DIV_STAGES   = DIV_W;
   localparam int CSR_IDX_W    = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_AC1        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_AC2        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_AC3        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_AC4        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_B1         = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_B2         = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_TEMP_PAIR  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_CURVE_PAIR = 3'd7;

   localparam logic [15:0] RST_AC1        = 16'd408;
   localparam logic [15:0] RST_AC2        = 16'hFFB8;
   localparam logic [15:0] RST_AC3        = 16'hC7D1;
   localparam logic [15:0] RST_AC4        = 16'd32741;
   localparam logic [15:0] RST_B1         = 16'd6190;
   localparam logic [15:0] RST_B2         = 16'd4;
   localparam logic [31:0] RST_TEMP_PAIR  = 32'd2146785905;
   localparam logic [31:0] RST_CURVE_PAIR = 32'd3724086068;

   localparam logic [31:0] C_B6_OFS  = 32'd4000;
   localparam logic [31:0] C_B4_OFS  = 32'd32768;
   localparam logic [31:0] C_B7_MUL  = 32'(50000 >> OVERSAMPLING);
   localparam logic [31:0] C_P_SQ    = 32'd3038;
   localparam logic [31:0] C_P_LIN   = 32'hFFFF_E343;
   localparam logic [31:0] C_P_OFS   = 32'd3791;

   typedef struct packed {
      logic [31:0]     x1;
      logic            neg;
      logic            fault;
      logic [UP_W-1:0] up;
   } side_a_type;

   typedef struct packed {
      logic dbl;
      logic fault;
   } side_b_type;

   function automatic logic [31:0] sx16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned n);
      return 32'($signed(v) >>> n);
   endfunction

endpackage

`default_nettype wire

@@ design/bpc_udiv.sv @@
`default_nettype none

// restoring unsigned divider, one quotient bit per stage
module bpc_udiv (
   input  wire logic                      clock,
   input  wire logic                      advance,
   input  wire logic [bpc_pkg::DIV_W-1:0] num,
   input  wire logic [bpc_pkg::DIV_W-1:0] den,
   output logic      [bpc_pkg::DIV_W-1:0] quo
);
   import bpc_pkg::*;

   logic [DIV_W-1:0] rem_ff [DIV_STAGES];
   logic [DIV_W-1:0] nq_ff  [DIV_STAGES];
   logic [DIV_W-1:0] den_ff [DIV_STAGES];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      logic [DIV_W-1:0] rem_i, nq_i, den_i;
      logic [DIV_W:0]   trial;
      logic [DIV_W-1:0] rem_in, nq_in;

      if (k == 0) begin : g_first
         assign rem_i = '0;
         assign nq_i  = num;
         assign den_i = den;
      end else begin : g_next
         assign rem_i = rem_ff[k-1];
         assign nq_i  = nq_ff[k-1];
         assign den_i = den_ff[k-1];
      end

      assign trial  = {rem_i, nq_i[DIV_W-1]} - {1'b0, den_i};
      assign rem_in = trial[DIV_W] ? {rem_i[DIV_W-2:0], nq_i[DIV_W-1]} : trial[DIV_W-1:0];
      assign nq_in  = {nq_i[DIV_W-2:0], ~trial[DIV_W]};

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k] <= rem_in;
            nq_ff[k]  <= nq_in;
            den_ff[k] <= den_i;
         end
      end
   end

   assign quo = nq_ff[DIV_STAGES-1];

endmodule

`default_nettype wire

@@ design/barometric_pressure_compensation.sv @@
// barometric pressure compensation, integer datasheet sequence
// request channel: req_valid / req_stall with raw_temperature and raw_pressure;
// one beat in gives exactly one beat out on the rsp channel
// result beat: pressure_pa (32-bit wrap) and divide_fault, set with pressure 0
// when the temperature divisor (x1 + md) or the pressure divisor b4 is zero
// calibration words are written through csr_write / csr_index / csr_data;
// write them only while no beat is in flight, the block does not enforce it;
// reset loads the factory default words
// throughput: one beat per cycle when not stalled; the latency is set by two
// 32-stage bit-per-stage dividers plus 14 arithmetic stages, all in lockstep
// reset clears every valid bit, including the one of the result beat
// when the receiver stalls a waiting result, the whole pipeline holds and
// req_stall rises; nothing is dropped or repeated, and it moves again as
// soon as the result beat is taken
`default_nettype none

module barometric_pressure_compensation (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [15:0]                    req_raw_temperature,
   input  wire logic [23:0]                    req_raw_pressure,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic signed [31:0]                  rsp_pressure_pa,
   output logic                                rsp_divide_fault,
   input  wire logic                           csr_write,
   input  wire logic [bpc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [31:0]                    csr_data
);
   import bpc_pkg::*;

   // calibration registers
   logic [15:0] ac1_ff, ac2_ff, ac3_ff, ac4_ff, b1_ff, b2_ff;
   logic [31:0] temp_pair_ff, curve_pair_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ac1_ff        <= RST_AC1;
         ac2_ff        <= RST_AC2;
         ac3_ff        <= RST_AC3;
         ac4_ff        <= RST_AC4;
         b1_ff         <= RST_B1;
         b2_ff         <= RST_B2;
         temp_pair_ff  <= RST_TEMP_PAIR;
         curve_pair_ff <= RST_CURVE_PAIR;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_AC1:        ac1_ff        <= csr_data[15:0];
            REG_AC2:        ac2_ff        <= csr_data[15:0];
            REG_AC3:        ac3_ff        <= csr_data[15:0];
            REG_AC4:        ac4_ff        <= csr_data[15:0];
            REG_B1:         b1_ff         <= csr_data[15:0];
            REG_B2:         b2_ff         <= csr_data[15:0];
            REG_TEMP_PAIR:  temp_pair_ff  <= csr_data;
            REG_CURVE_PAIR: curve_pair_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   logic [31:0] ac5, ac6, mc, md;
   assign ac5 = {16'd0, temp_pair_ff[31:16]};
   assign ac6 = {16'd0, temp_pair_ff[15:0]};
   assign mc  = sx16(curve_pair_ff[31:16]);
   assign md  = sx16(curve_pair_ff[15:0]);

   // global lockstep advance: everything moves unless a held result is stalled
   logic advance;
   logic rsp_valid_ff;
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // s0: input register
   logic            v0_ff;
   logic [15:0]     ut0_ff;
   logic [UP_W-1:0] up0_ff;
   // s1: temperature product
   logic            v1_ff;
   logic [31:0]     prod1_ff;
   logic [UP_W-1:0] up1_ff;
   // s2: x1 and temperature divisor
   logic            v2_ff;
   logic [31:0]     x1_2_ff, div2_ff;
   logic [UP_W-1:0] up2_ff;
   // s3: magnitudes for divider a
   logic            v3_ff;
   logic [31:0]     ua_ff, ub_ff;
   side_a_type      sa3_ff;

   logic [31:0] mc_sh, ua_in, ub_in;
   assign mc_sh = mc << 11;
   assign ua_in = mc_sh[31] ? (32'd0 - mc_sh) : mc_sh;
   assign ub_in = div2_ff[31] ? (32'd0 - div2_ff) : div2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v0_ff <= req_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ut0_ff       <= req_raw_temperature;
         up0_ff       <= UP_W'(req_raw_pressure >> (8 - OVERSAMPLING));
         prod1_ff     <= ({16'd0, ut0_ff} - ac6) * ac5;
         up1_ff       <= up0_ff;
         x1_2_ff      <= asr(prod1_ff, 15);
         div2_ff      <= asr(prod1_ff, 15) + md;
         up2_ff       <= up1_ff;
         ua_ff        <= ua_in;
         ub_ff        <= ub_in;
         sa3_ff.x1    <= x1_2_ff;
         sa3_ff.neg   <= mc_sh[31] ^ div2_ff[31];
         sa3_ff.fault <= (div2_ff == 32'd0);
         sa3_ff.up    <= up2_ff;
      end
   end

   // divider a: temperature term, sideband travels alongside
   logic [31:0] qa;
   bpc_udiv u_div_a (
      .clock   (clock),
      .advance (advance),
      .num     (ua_ff),
      .den     (ub_ff),
      .quo     (qa)
   );

   logic       va_ff [DIV_STAGES];
   side_a_type sa_ff [DIV_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_STAGES; k++) va_ff[k] <= 1'b0;
      end else if (advance) begin
         va_ff[0] <= v3_ff;
         for (int k = 1; k < DIV_STAGES; k++) va_ff[k] <= va_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sa_ff[0] <= sa3_ff;
         for (int k = 1; k < DIV_STAGES; k++) sa_ff[k] <= sa_ff[k-1];
      end
   end

   side_a_type sa_out;
   logic [31:0] x2_a;
   assign sa_out = sa_ff[DIV_STAGES-1];
   assign x2_a   = sa_out.neg ? (32'd0 - qa) : qa;

   // d1: b6
   logic v_d1_ff, f_d1_ff;
   logic [31:0] b6_ff;
   logic [UP_W-1:0] up_d1_ff;
   // e1: first products
   logic v_e1_ff, f_e1_ff;
   logic [31:0] sq_ff, mac2_ff, mac3_ff;
   logic [UP_W-1:0] up_e1_ff;
   // e2: second-order products
   logic v_e2_ff, f_e2_ff;
   logic [31:0] mb2_ff, mb1_ff, ac2s_ff, ac3s_ff;
   logic [UP_W-1:0] up_e2_ff;
   // e3: b3 and scale term
   logic v_e3_ff, f_e3_ff;
   logic [31:0] b3_ff, x3b_ff;
   logic [UP_W-1:0] up_e3_ff;
   // e4: b4 product and b7
   logic v_e4_ff, f_e4_ff;
   logic [31:0] b4p_ff, b7_ff;
   // e5: divider b operands
   logic v_e5_ff;
   logic [31:0] numb_ff, b4_ff;
   side_b_type sb5_ff;

   logic [31:0] sq12, b3_t, b3_in, x3b_in, b4_in;
   assign sq12   = asr(sq_ff, 12);
   assign b3_t   = (sx16(ac1_ff) << 2) + (asr(mb2_ff, 11) + ac2s_ff);
   assign b3_in  = asr((b3_t << OVERSAMPLING) + 32'd2, 2);
   assign x3b_in = asr(ac3s_ff + asr(mb1_ff, 16) + 32'd2, 2);
   assign b4_in  = b4p_ff >> 15;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_d1_ff <= 1'b0;
         v_e1_ff <= 1'b0;
         v_e2_ff <= 1'b0;
         v_e3_ff <= 1'b0;
         v_e4_ff <= 1'b0;
         v_e5_ff <= 1'b0;
      end else if (advance) begin
         v_d1_ff <= va_ff[DIV_STAGES-1];
         v_e1_ff <= v_d1_ff;
         v_e2_ff <= v_e1_ff;
         v_e3_ff <= v_e2_ff;
         v_e4_ff <= v_e3_ff;
         v_e5_ff <= v_e4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b6_ff        <= sa_out.x1 + x2_a - C_B6_OFS;
         f_d1_ff      <= sa_out.fault;
         up_d1_ff     <= sa_out.up;

         sq_ff        <= b6_ff * b6_ff;
         mac2_ff      <= sx16(ac2_ff) * b6_ff;
         mac3_ff      <= sx16(ac3_ff) * b6_ff;
         f_e1_ff      <= f_d1_ff;
         up_e1_ff     <= up_d1_ff;

         mb2_ff       <= sx16(b2_ff) * sq12;
         mb1_ff       <= sx16(b1_ff) * sq12;
         ac2s_ff      <= asr(mac2_ff, 11);
         ac3s_ff      <= asr(mac3_ff, 13);
         f_e2_ff      <= f_e1_ff;
         up_e2_ff     <= up_e1_ff;

         b3_ff        <= b3_in;
         x3b_ff       <= x3b_in;
         f_e3_ff      <= f_e2_ff;
         up_e3_ff     <= up_e2_ff;

         b4p_ff       <= {16'd0, ac4_ff} * (x3b_ff + C_B4_OFS);
         b7_ff        <= (32'(up_e3_ff) - b3_ff) * C_B7_MUL;
         f_e4_ff      <= f_e3_ff;

         b4_ff        <= b4_in;
         numb_ff      <= b7_ff[31] ? b7_ff : (b7_ff << 1);
         sb5_ff.dbl   <= b7_ff[31];
         sb5_ff.fault <= f_e4_ff || (b4_in == 32'd0);
      end
   end

   // divider b: pressure quotient
   logic [31:0] qb;
   bpc_udiv u_div_b (
      .clock   (clock),
      .advance (advance),
      .num     (numb_ff),
      .den     (b4_ff),
      .quo     (qb)
   );

   logic       vb_ff [DIV_STAGES];
   side_b_type sb_ff [DIV_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_STAGES; k++) vb_ff[k] <= 1'b0;
      end else if (advance) begin
         vb_ff[0] <= v_e5_ff;
         for (int k = 1; k < DIV_STAGES; k++) vb_ff[k] <= vb_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sb_ff[0] <= sb5_ff;
         for (int k = 1; k < DIV_STAGES; k++) sb_ff[k] <= sb_ff[k-1];
      end
   end

   side_b_type sb_out;
   assign sb_out = sb_ff[DIV_STAGES-1];

   // f1..f3: final correction polynomial
   logic v_f1_ff, v_f2_ff, v_f3_ff;
   logic f_f1_ff, f_f2_ff, f_f3_ff;
   logic [31:0] p1_ff, p2_ff, p3_ff, t2_ff, u2_ff, u3_ff, w3_ff;
   logic [31:0] p8, pa_in;
   logic [31:0] rsp_pressure_ff;
   logic        rsp_fault_ff;

   assign p8    = asr(p1_ff, 8);
   assign pa_in = p3_ff + asr(w3_ff + u3_ff + C_P_OFS, 4);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_f1_ff      <= 1'b0;
         v_f2_ff      <= 1'b0;
         v_f3_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         v_f1_ff      <= vb_ff[DIV_STAGES-1];
         v_f2_ff      <= v_f1_ff;
         v_f3_ff      <= v_f2_ff;
         rsp_valid_ff <= v_f3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p1_ff           <= sb_out.dbl ? (qb << 1) : qb;
         f_f1_ff         <= sb_out.fault;
         t2_ff           <= p8 * p8;
         u2_ff           <= asr(C_P_LIN * p1_ff, 16);
         p2_ff           <= p1_ff;
         f_f2_ff         <= f_f1_ff;
         w3_ff           <= asr(t2_ff * C_P_SQ, 16);
         u3_ff           <= u2_ff;
         p3_ff           <= p2_ff;
         f_f3_ff         <= f_f2_ff;
         rsp_pressure_ff <= f_f3_ff ? 32'd0 : pa_in;
         rsp_fault_ff    <= f_f3_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pressure_pa  = $signed(rsp_pressure_ff);
   assign rsp_divide_fault = rsp_fault_ff;

endmodule

`default_nettype wire
